>>> rtl/fan_tacho_monitor_unit_defines.svh
// Assertion macros for the fan tacho monitor.
// Used by fan_tacho_monitor_unit; no other dependencies.
`ifndef FAN_TACHO_MONITOR_UNIT_DEFINES_SVH
`define FAN_TACHO_MONITOR_UNIT_DEFINES_SVH

// same-cycle implication
`define FMON_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("fan tacho monitor check failed");

// next-cycle implication
`define FMON_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("fan tacho monitor check failed");

`endif

>>> rtl/fmon_pkg.sv
// Shared types and constants for the fan tacho monitor.
// No dependencies.
`default_nettype none

package fmon_pkg;

  localparam int unsigned RPM_W    = 28;
  localparam int unsigned DIVD_W   = 22;
  localparam int unsigned DIVS_W   = 16;
  localparam int unsigned DIV_STEPS = DIVD_W;
  localparam int unsigned CFG_IDX_W = 3;

  // rpm = floor(TACHO_NUM / period) * 60
  localparam logic [DIVD_W-1:0] TACHO_NUM = 22'd2500000;
  localparam logic [RPM_W-1:0]  RPM_MAX   = 28'd150000000;

  typedef logic [RPM_W-1:0] rpm_t;

  typedef enum logic [0:0] {
    OP_TICK    = 1'b0,
    OP_CAPTURE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    MODE_OFF = 2'd0,
    MODE_LOW = 2'd1,
    MODE_MED = 2'd2,
    MODE_MAX = 2'd3
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAN_MODES  = 3'd0,
    CFG_DWELL      = 3'd1,
    CFG_LOW_RPM    = 3'd2,
    CFG_MED_RPM    = 3'd3,
    CFG_MAX_RPM    = 3'd4,
    CFG_MARGIN     = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

  // reset values of the configuration registers
  localparam logic [15:0] RST_FAN_MODES = 16'd21845;
  localparam logic [15:0] RST_DWELL     = 16'd10000;
  localparam logic [15:0] RST_LOW_RPM   = 16'd3500;
  localparam logic [15:0] RST_MED_RPM   = 16'd8000;
  localparam logic [15:0] RST_MAX_RPM   = 16'd13100;
  localparam logic [15:0] RST_MARGIN    = 16'd1500;

  // floor(9 * duty / 100) for duties 0, 40, 70, 100
  localparam logic [3:0] CMP_OFF = 4'd0;
  localparam logic [3:0] CMP_LOW = 4'd3;
  localparam logic [3:0] CMP_MED = 4'd6;
  localparam logic [3:0] CMP_MAX = 4'd9;

  function automatic logic [3:0] duty_cmp(input mode_e mode);
    logic [3:0] c;
    case (mode)
      MODE_LOW: c = CMP_LOW;
      MODE_MED: c = CMP_MED;
      MODE_MAX: c = CMP_MAX;
      default:  c = CMP_OFF;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/fan_tacho_monitor_unit.sv
// Fan tacho monitor: tick/capture requests in, one status result per request.
// A tick or zero-period capture goes straight to the result load; a nonzero-period
// capture first runs the serial divider (22 steps) and the store into the rpm slot.
// Throughput: one request in flight; the next accept waits until the result is
// loaded, which waits while the result register is stalled. Reset (async, active
// low) loads register defaults and clears the rpm store at once: no clearing pass.
`default_nettype none
`include "fan_tacho_monitor_unit_defines.svh"

module fan_tacho_monitor_unit
  import fmon_pkg::*;
#(
  parameter int unsigned NUM_FANS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [15:0]          cfg_wdata_i,
  // request channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 in_opcode_i,
  input  wire logic [15:0]          in_capture_period_i,
  input  wire logic [2:0]           in_query_fan_i,
  // result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [2:0]                out_active_channel_o,
  output logic [RPM_W-1:0]          out_fan_rpm_o,
  output logic                      out_too_slow_o,
  output logic [3:0]                out_duty_compare_o
);

  localparam int unsigned CH_W = $clog2(NUM_FANS);

  // configuration registers
  logic [15:0] fan_modes_q, dwell_q, low_rpm_q, med_rpm_q, max_rpm_q, margin_q;

  // monitor state
  logic [15:0]   tick_q, tick_d;
  logic [CH_W-1:0] channel_q, channel_d;
  rpm_t          rpm_q [NUM_FANS];

  // sequencer
  state_e state_q, state_d;
  logic   in_acc, div_start, store_we, out_load, slot_free;
  logic [2:0] fan_q;

  // divider
  logic              div_done;
  logic [DIVD_W-1:0] div_quot;
  rpm_t              rpm_new;

  // result
  logic        out_valid_q;
  logic [2:0]  out_chan_q;
  rpm_t        out_rpm_q;
  logic        out_slow_q;
  logic [3:0]  out_cmp_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fan_modes_q <= RST_FAN_MODES;
      dwell_q     <= RST_DWELL;
      low_rpm_q   <= RST_LOW_RPM;
      med_rpm_q   <= RST_MED_RPM;
      max_rpm_q   <= RST_MAX_RPM;
      margin_q    <= RST_MARGIN;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FAN_MODES: fan_modes_q <= cfg_wdata_i;
        CFG_DWELL:     dwell_q     <= cfg_wdata_i;
        CFG_LOW_RPM:   low_rpm_q   <= cfg_wdata_i;
        CFG_MED_RPM:   med_rpm_q   <= cfg_wdata_i;
        CFG_MAX_RPM:   max_rpm_q   <= cfg_wdata_i;
        CFG_MARGIN:    margin_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer: IDLE -> (DIV -> MUL ->) DONE -> IDLE
  // ---------------------------------------------------------------------
  assign in_acc    = in_valid_i && (state_q == ST_IDLE);
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if ((op_e'(in_opcode_i) == OP_CAPTURE) && (in_capture_period_i != '0)) begin
            state_d = ST_DIV;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_MUL;
        end
      end
      ST_MUL:  state_d = ST_DONE;
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    div_start  = in_acc && (op_e'(in_opcode_i) == OP_CAPTURE) &&
                 (in_capture_period_i != '0);
    store_we   = (state_q == ST_MUL);
    out_load   = (state_q == ST_DONE) && slot_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      fan_q <= in_query_fan_i;
    end
  end

  // ---------------------------------------------------------------------
  // Tick counter and channel rotation, applied at accept
  // ---------------------------------------------------------------------
  logic [16:0] tick_inc;
  assign tick_inc = {1'b0, tick_q} + 17'd1;

  always_comb begin
    tick_d    = tick_q;
    channel_d = channel_q;
    if (in_acc && (op_e'(in_opcode_i) == OP_TICK)) begin
      if (tick_inc < {1'b0, dwell_q}) begin
        tick_d = tick_inc[15:0];
      end else begin
        tick_d = '0;
        if (channel_q == CH_W'(NUM_FANS - 1)) begin
          channel_d = '0;
        end else begin
          channel_d = channel_q + CH_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q    <= '0;
      channel_q <= '0;
    end else begin
      tick_q    <= tick_d;
      channel_q <= channel_d;
    end
  end

  // ---------------------------------------------------------------------
  // Period to rpm: shared serial divider, then x60 as shift-subtract
  // ---------------------------------------------------------------------
  fmon_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .divisor_i (in_capture_period_i),
    .done_o    (div_done),
    .quot_o    (div_quot)
  );

  // q*60 = q*64 - q*4; fits 28 bits since q <= 2500000
  assign rpm_new = {div_quot, 6'b0} - {4'b0, div_quot, 2'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_FANS; i++) begin
        rpm_q[i] <= '0;
      end
    end else if (store_we) begin
      rpm_q[channel_q] <= rpm_new;
    end
  end

  // ---------------------------------------------------------------------
  // Result for the queried fan
  // ---------------------------------------------------------------------
  logic [CH_W+2:0] fan_ext, chan_ext;
  logic [CH_W-1:0] fan_idx;
  logic            fan_ok;
  mode_e           mode;
  logic [15:0]     expected;
  rpm_t            res_rpm;
  logic            res_slow;
  logic [3:0]      res_cmp;
  logic signed [RPM_W+1:0] lhs, rhs;

  assign fan_ext  = {{CH_W{1'b0}}, fan_q};
  assign chan_ext = {3'b000, channel_q};
  assign fan_idx  = fan_ext[CH_W-1:0];
  assign fan_ok   = (int'(fan_q) < NUM_FANS);
  assign mode     = mode_e'(fan_modes_q[{fan_q, 1'b0} +: 2]);

  always_comb begin
    case (mode)
      MODE_LOW: expected = low_rpm_q;
      MODE_MED: expected = med_rpm_q;
      MODE_MAX: expected = max_rpm_q;
      default:  expected = '0;
    endcase
  end

  assign res_rpm  = fan_ok ? rpm_q[fan_idx] : '0;
  // signed compare: rpm < expected - margin
  assign lhs      = $signed({2'b00, res_rpm});
  assign rhs      = $signed({14'b0, expected}) - $signed({14'b0, margin_q});
  assign res_slow = fan_ok && (lhs < rhs);
  assign res_cmp  = fan_ok ? duty_cmp(mode) : CMP_OFF;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_chan_q <= chan_ext[2:0];
      out_rpm_q  <= res_rpm;
      out_slow_q <= res_slow;
      out_cmp_q  <= res_cmp;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign out_active_channel_o = out_chan_q;
  assign out_fan_rpm_o        = out_rpm_q;
  assign out_too_slow_o       = out_slow_q;
  assign out_duty_compare_o   = out_cmp_q;

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `FMON_ASSERT_NOW(a_div_done_in_div, clk_i, rst_ni, div_done, state_q == ST_DIV)
  `FMON_ASSERT_NOW(a_rpm_in_range, clk_i, rst_ni, store_we, rpm_new <= RPM_MAX)
  `FMON_ASSERT_NEXT(a_load_sets_valid, clk_i, rst_ni, out_load, out_valid_q && state_q == ST_IDLE)
  `FMON_ASSERT_NEXT(a_accept_leaves_idle, clk_i, rst_ni, in_acc, state_q != ST_IDLE)

endmodule

`default_nettype wire

>>> rtl/fmon_div.sv
// Serial restoring divider: TACHO_NUM / divisor, one quotient bit per cycle.
// Depends on fmon_pkg.
`default_nettype none

module fmon_div
  import fmon_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DIVS_W-1:0] divisor_i,
  output logic                   done_o,
  output logic [DIVD_W-1:0]      quot_o
);

  localparam int unsigned CNT_W = $clog2(DIV_STEPS);

  logic              busy_q, busy_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [DIVS_W-1:0] dvs_q, dvs_d;
  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVD_W-1:0] quo_q, quo_d;

  logic [DIVS_W:0]   rem_sh;
  logic [DIVS_W+1:0] diff;
  logic              last;

  assign rem_sh = {rem_q, quo_q[DIVD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs_q};
  assign last   = busy_q && (cnt_q == CNT_W'(DIV_STEPS - 1));

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvs_d  = divisor_i;
      rem_d  = '0;
      quo_d  = TACHO_NUM;
    end else if (busy_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (!diff[DIVS_W+1]) begin
        rem_d = diff[DIVS_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh[DIVS_W-1:0];
        quo_d = {quo_q[DIVD_W-2:0], 1'b0};
      end
      if (last) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = last;
  assign quot_o = quo_q;

endmodule

`default_nettype wire

>>> tb/fan_tacho_monitor_unit_test.sv
// Self-checking testbench for fan_tacho_monitor_unit: tick and capture requests,
// register writes and status results checked against an in-bench predictor.
// Depends on fmon_pkg and the fan_tacho_monitor_unit RTL.

module fan_tacho_monitor_unit_test;
  import fmon_pkg::*;

  localparam int unsigned FANS         = 8;
  localparam int unsigned IDLE_LIMIT   = 5000;  // cycles with no handshake at all
  localparam int unsigned DRAIN_CYCLES = 40;    // well past a full divide
  localparam int unsigned SEGMENTS     = 16;    // four idling phases, four settings each
  localparam int unsigned SEG_REQS     = 125;

  typedef struct packed {
    op_e         op;
    logic [15:0] period;
    logic [2:0]  fan;
  } tacho_req_t;

  typedef struct packed {
    logic [2:0] chan;
    rpm_t       rpm;
    logic       slow;
    logic [3:0] cmp;
  } fan_status_t;

  // DUT inputs, all known from time zero
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_valid   = 1'b0;
  cfg_idx_e   cfg_index   = CFG_FAN_MODES;
  logic [15:0] cfg_wdata  = '0;
  logic       req_valid   = 1'b0;
  logic       req_opcode  = 1'b0;
  logic [15:0] req_period = '0;
  logic [2:0] req_fan     = '0;
  logic       res_stall   = 1'b0;

  // DUT outputs
  logic       cfg_ready_o;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [2:0] out_active_channel_o;
  rpm_t       out_fan_rpm_o;
  logic       out_too_slow_o;
  logic [3:0] out_duty_compare_o;

  fan_tacho_monitor_unit #(
    .NUM_FANS(FANS)
  ) u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (req_valid),
    .in_stall_o          (in_stall_o),
    .in_opcode_i         (req_opcode),
    .in_capture_period_i (req_period),
    .in_query_fan_i      (req_fan),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (res_stall),
    .out_active_channel_o(out_active_channel_o),
    .out_fan_rpm_o       (out_fan_rpm_o),
    .out_too_slow_o      (out_too_slow_o),
    .out_duty_compare_o  (out_duty_compare_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow copy of the monitor: registers, tick counter, channel, rpm store.
  logic [15:0] sh_modes  = RST_FAN_MODES;
  logic [15:0] sh_dwell  = RST_DWELL;
  logic [15:0] sh_low    = RST_LOW_RPM;
  logic [15:0] sh_med    = RST_MED_RPM;
  logic [15:0] sh_max    = RST_MAX_RPM;
  logic [15:0] sh_margin = RST_MARGIN;
  logic [15:0] sh_ticks  = '0;
  logic [2:0]  sh_chan   = '0;
  rpm_t        sh_rpm [FANS] = '{default: '0};

  tacho_req_t  req_backlog[$];      // requests not yet presented
  fan_status_t status_expected[$];  // predicted results, oldest first
  tacho_req_t  req_cur;             // request on the input port
  logic        req_taken = 1'b0;    // set at the edge that accepted req_cur

  int unsigned send_gap_pct   = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned err_count      = 0;
  int unsigned quiet_cycles   = 0;

  // Applies one request to the shadow state and returns the status it yields.
  function automatic fan_status_t advance_monitor(tacho_req_t r);
    logic [16:0] nxt;
    mode_e       mode;
    longint      goal;
    int unsigned duty;
    fan_status_t s;
    if (r.op == OP_TICK) begin
      nxt = {1'b0, sh_ticks} + 17'd1;
      // dwell at or below the count (zero included) advances on this tick
      if (nxt < {1'b0, sh_dwell}) begin
        sh_ticks = nxt[15:0];
      end else begin
        sh_ticks = '0;
        sh_chan  = sh_chan + 3'd1;
      end
    end else if (r.period != 16'd0) begin
      // zero period keeps the old reading
      sh_rpm[sh_chan] = rpm_t'((32'd2500000 / {16'd0, r.period}) * 32'd60);
    end
    mode = mode_e'(sh_modes[2*r.fan +: 2]);
    case (mode)
      MODE_LOW: begin
        goal = sh_low;
        duty = 40;
      end
      MODE_MED: begin
        goal = sh_med;
        duty = 70;
      end
      MODE_MAX: begin
        goal = sh_max;
        duty = 100;
      end
      default: begin
        goal = 0;
        duty = 0;
      end
    endcase
    s.chan = sh_chan;
    s.rpm  = sh_rpm[r.fan];
    // signed compare: threshold may go negative, off mode never flags
    s.slow = (longint'(s.rpm) < goal - longint'(sh_margin));
    s.cmp  = 4'((9 * duty) / 100);
    return s;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  function automatic void queue_req(op_e op, logic [15:0] period, logic [2:0] fan);
    tacho_req_t r;
    r.op     = op;
    r.period = period;
    r.fan    = fan;
    req_backlog.push_back(r);
  endfunction

  // Mostly ticks and realistic periods, with zero, tiny and full-range ones.
  function automatic tacho_req_t random_req();
    tacho_req_t  r;
    int unsigned pick;
    pick     = $urandom_range(9);
    r.op     = ($urandom_range(99) < 55) ? OP_TICK : OP_CAPTURE;
    r.fan    = 3'($urandom_range(7));
    if (pick == 0)      r.period = '0;
    else if (pick == 1) r.period = 16'($urandom_range(40, 1));
    else if (pick < 4)  r.period = 16'($urandom);
    else                r.period = 16'($urandom_range(65535, 8000));
    return r;
  endfunction

  // Register write; only called with no request in flight.
  task automatic write_reg(cfg_idx_e idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_FAN_MODES: sh_modes  = val;
      CFG_DWELL:     sh_dwell  = val;
      CFG_LOW_RPM:   sh_low    = val;
      CFG_MED_RPM:   sh_med    = val;
      CFG_MAX_RPM:   sh_max    = val;
      CFG_MARGIN:    sh_margin = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_settings(logic [15:0] modes, logic [15:0] dwell, logic [15:0] lo,
                               logic [15:0] med, logic [15:0] mx, logic [15:0] margin);
    write_reg(CFG_FAN_MODES, modes);
    write_reg(CFG_DWELL, dwell);
    write_reg(CFG_LOW_RPM, lo);
    write_reg(CFG_MED_RPM, med);
    write_reg(CFG_MAX_RPM, mx);
    write_reg(CFG_MARGIN, margin);
  endtask

  // Block is idle once every request went in and every result came back.
  task automatic wait_drained();
    do @(posedge clk_i);
    while (req_backlog.size() != 0 || req_valid || status_expected.size() != 0);
  endtask

  // Request acceptance: predict at the edge the request is taken.
  always @(posedge clk_i) begin
    if (rst_ni && req_valid && !in_stall_o) begin
      status_expected.push_back(advance_monitor(req_cur));
      req_taken = 1'b1;
    end
  end

  // Driver: a new request goes out only once the previous one was taken,
  // so a stalled request holds its payload. Receiver stall is drawn here too.
  always @(negedge clk_i) begin
    if (rst_ni && (!req_valid || req_taken)) begin
      req_taken = 1'b0;
      if (req_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        req_cur = req_backlog.pop_front();
        req_valid  <= 1'b1;
        req_opcode <= req_cur.op;
        req_period <= req_cur.period;
        req_fan    <= req_cur.fan;
      end else begin
        req_valid <= 1'b0;
      end
    end
    res_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: each accepted result against the oldest prediction.
  always @(posedge clk_i) begin
    fan_status_t want;
    if (rst_ni && out_valid_o && !res_stall) begin
      if (status_expected.size() == 0) begin
        $display("%0t: unexpected result, channel %0d rpm %0d", $time,
                 out_active_channel_o, out_fan_rpm_o);
        err_count++;
      end else begin
        want = status_expected.pop_front();
        check_field("active_channel", want.chan, out_active_channel_o);
        check_field("fan_rpm", want.rpm, out_fan_rpm_o);
        check_field("too_slow", want.slow, out_too_slow_o);
        check_field("duty_compare", want.cmp, out_duty_compare_o);
      end
    end
  end

  // Watchdog: any handshake on any channel restarts the count.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req_valid && !in_stall_o) || (out_valid_o && !res_stall) ||
          (cfg_valid && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= IDLE_LIMIT) begin
          $display("FAILURE");
          $finish;
        end
      end
    end
  end

  initial begin
    logic [15:0] dwell;
    int unsigned pick;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset settings, store starts at zero, so low-mode fans flag slow.
    queue_req(OP_CAPTURE, 16'd0, 3'd0);       // zero period on an empty slot
    queue_req(OP_CAPTURE, 16'd1, 3'd0);       // shortest period, top rpm
    queue_req(OP_CAPTURE, 16'd0, 3'd0);       // zero period keeps top rpm
    queue_req(OP_TICK, 16'hFFFF, 3'd7);
    queue_req(OP_CAPTURE, 16'hFFFF, 3'd0);    // longest period
    for (int f = 1; f < FANS; f++) queue_req(OP_TICK, 16'($urandom), 3'(f));
    wait_drained();

    // All four modes side by side; lower dwell below the running count.
    write_reg(CFG_FAN_MODES, 16'hE4E4);
    write_reg(CFG_DWELL, 16'd5);
    for (int f = 0; f < 3; f++) queue_req(OP_TICK, 16'd0, 3'(f));
    queue_req(OP_CAPTURE, 16'd187, 3'd3);
    wait_drained();
    write_reg(CFG_DWELL, 16'd2);
    queue_req(OP_TICK, 16'd0, 3'd0);          // count already at dwell
    queue_req(OP_CAPTURE, 16'd312, 3'd1);
    wait_drained();
    write_reg(CFG_DWELL, 16'd0);               // every tick advances
    queue_req(OP_TICK, 16'd0, 3'd2);
    queue_req(OP_TICK, 16'd0, 3'd3);
    queue_req(OP_CAPTURE, 16'd0, 3'd2);
    queue_req(OP_CAPTURE, 16'd18750, 3'd3);
    wait_drained();

    // Random segments; idling phase changes every four segments.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg / 4)
        0: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_gap_pct   = 83;
          recv_stall_pct = 0;
        end
        2: begin
          send_gap_pct   = 0;
          recv_stall_pct = 83;
        end
        default: begin
          send_gap_pct   = 22;
          recv_stall_pct = 22;
        end
      endcase
      if (seg == 1) begin
        load_settings('0, '0, '0, '0, '0, '0);
      end else if (seg == 6) begin
        load_settings('1, '1, '1, '1, '1, '1);
      end else begin
        // short dwell most of the time so the channel walks all fans
        pick = $urandom_range(9);
        if (pick < 6)       dwell = 16'($urandom_range(6, 1));
        else if (pick < 8)  dwell = 16'($urandom_range(40, 7));
        else if (pick == 8) dwell = '0;
        else                dwell = 16'($urandom);
        load_settings(16'($urandom), dwell, 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom_range(3000)));
      end
      for (int n = 0; n < SEG_REQS; n++) req_backlog.push_back(random_req());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
